@@ src/bll_pkg.sv @@
package bll_pkg;

  localparam int unsigned KW_COUNT    = 16;
  localparam int unsigned KW_MAX_LEN  = 10;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned COUNT_BITS  = 7;

  typedef logic [4:0] token_kind_t;

  localparam token_kind_t TK_LPAREN = 5'd0;
  localparam token_kind_t TK_RPAREN = 5'd1;
  localparam token_kind_t TK_BOOL   = 5'd2;
  localparam token_kind_t TK_BITVEC = 5'd3;
  localparam token_kind_t TK_IDENT  = 5'd4;
  localparam token_kind_t TK_EOF    = 5'd18;
  localparam token_kind_t TK_ERROR  = 5'd19;

  localparam logic IN_CHAR = 1'b0;
  localparam logic IN_END  = 1'b1;

  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0d;
  localparam logic [7:0] CH_LF         = 8'h0a;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_ONE        = 8'h31;
  localparam logic [7:0] CH_B          = 8'h62;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
  localparam logic [7:0] CH_LOWER_A    = 8'h61;
  localparam logic [7:0] CH_LOWER_Z    = 8'h7a;
  localparam logic [7:0] CH_UPPER_A    = 8'h41;
  localparam logic [7:0] CH_UPPER_Z    = 8'h5a;

  // spellings right aligned, first character in the highest used byte
  localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
    "not", "and", "nand", "or", "nor", "xor", "xnor", "false",
    "False", "true", "True", "print", "return", "circuit", "bit", {"bit_", "vector"}
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd3, 4'd4, 4'd2, 4'd3, 4'd3, 4'd4, 4'd5,
    4'd5, 4'd4, 4'd4, 4'd5, 4'd6, 4'd7, 4'd3, 4'd10
  };

  localparam token_kind_t KW_KIND [KW_COUNT] = '{
    5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12,
    5'd12, 5'd13, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, TK_BITVEC
  };

  typedef struct packed {
    token_kind_t     token_kind;
    logic [15:0]     line_number;
    logic [31:0]     start_offset;
    logic [15:0]     token_length;
    logic [63:0]     bit_value;
    logic [COUNT_BITS-1:0] bit_count;
    logic            bit_overflow;
    logic [7:0]      bad_char;
    logic            last_of_run;
  } token_t;

  typedef struct packed {
    logic   v0;
    logic   v1;
    token_t t0;
    token_t t1;
  } push_t;

  // does keyword idx have character c at position pos
  function automatic logic kw_hit(input logic [3:0] idx, input logic [15:0] pos,
                                  input logic [7:0] c);
    logic [8*KW_MAX_LEN-1:0] text;
    logic [3:0]              len;
    logic [3:0]              back;
    text = KW_TEXT[idx];
    len  = KW_LEN[idx];
    back = len - pos[3:0] - 4'd1;
    return (pos < 16'(len)) ? (text[{back, 3'b000} +: 8] == c) : 1'b0;
  endfunction

endpackage

@@ src/bll_src_if.sv @@
interface bll_src_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] ch;

  modport source(output valid, kind, ch, input ready);
  modport sink(input valid, kind, ch, output ready);
endinterface

@@ src/bll_tok_if.sv @@
interface bll_tok_if;
  logic                  valid;
  logic                  ready;
  bll_pkg::token_kind_t  token_kind;
  logic [15:0]           line_number;
  logic [31:0]           start_offset;
  logic [15:0]           token_length;
  logic [63:0]           bit_value;
  logic [bll_pkg::COUNT_BITS-1:0] bit_count;
  logic                  bit_overflow;
  logic [7:0]            bad_char;
  logic                  last_of_run;

  modport source(output valid, token_kind, line_number, start_offset, token_length,
                 bit_value, bit_count, bit_overflow, bad_char, last_of_run,
                 input ready);
  modport sink(input valid, token_kind, line_number, start_offset, token_length,
               bit_value, bit_count, bit_overflow, bad_char, last_of_run,
               output ready);
endinterface

@@ src/boolean_language_lexer.sv @@
// a character word taken from the source is held in a register, then its tokens go into
// the output queue once that has room for a pair; throughput: one character per cycle
// while the queue has room; the output side moves one token per cycle, so characters that
// end a token and make one of their own are paced by the output port
// reset: synchronous, clears scanner state, line count to one, offsets to zero, queue empty
module boolean_language_lexer #(
  parameter int unsigned VALUE_BITS = 64,
  parameter int unsigned LINE_BITS  = 16
) (
  input  logic      clk,
  input  logic      rst,
  bll_src_if.sink   src,
  bll_tok_if.source tok
);

  logic           room;
  bll_pkg::push_t push;

  bll_core #(
    .VALUE_BITS(VALUE_BITS),
    .LINE_BITS (LINE_BITS)
  ) u_core (
    .clk (clk),
    .rst (rst),
    .src (src),
    .room(room),
    .push(push)
  );

  bll_queue u_queue (
    .clk (clk),
    .rst (rst),
    .push(push),
    .room(room),
    .tok (tok)
  );

endmodule

@@ src/bll_core.sv @@
module bll_core #(
  parameter int unsigned VALUE_BITS = 64,
  parameter int unsigned LINE_BITS  = 16
) (
  input  logic           clk,
  input  logic           rst,
  bll_src_if.sink        src,
  input  logic           room,
  output bll_pkg::push_t push
);

  typedef enum logic [1:0] {M_IDLE, M_ZERO, M_BITS, M_WORD} mode_t;

  logic                  held_v;
  logic                  held_kind;
  logic [7:0]            held_ch;

  mode_t                 mode, mode_next;
  logic [LINE_BITS-1:0]  line_count, line_count_next;
  logic [31:0]           byte_offset, byte_offset_next;
  logic [31:0]           token_start, token_start_next;
  logic [15:0]           lexeme_length, lexeme_length_next;
  logic [VALUE_BITS-1:0] bit_acc, bit_acc_next;
  logic [bll_pkg::COUNT_BITS-1:0] bits_seen, bits_seen_next;
  logic                  overflow_seen, overflow_seen_next;
  logic [bll_pkg::KW_COUNT-1:0] keyword_mask, keyword_mask_next;

  logic                  adv;
  logic [7:0]            c;
  logic                  is_letter, is_bit, consume;
  logic [bll_pkg::KW_COUNT-1:0] match_mask, first_mask;
  logic [15:0]           line_out;
  logic [15:0]           grown_length;
  bll_pkg::token_t       ft, rt, eof_tok, sec;
  logic                  flush_v, rt_v, first_v, sec_v;
  bll_pkg::token_kind_t  word_kind;

  assign adv       = held_v && room;
  assign src.ready = !held_v || adv;
  assign c         = held_ch;
  assign line_out  = 16'(line_count);

  assign is_letter = (c >= bll_pkg::CH_LOWER_A && c <= bll_pkg::CH_LOWER_Z) ||
                     (c >= bll_pkg::CH_UPPER_A && c <= bll_pkg::CH_UPPER_Z) ||
                     c == bll_pkg::CH_UNDERSCORE;
  assign is_bit    = c == bll_pkg::CH_ZERO || c == bll_pkg::CH_ONE;
  assign grown_length = (lexeme_length != 16'hffff) ? lexeme_length + 16'd1 : lexeme_length;

  always_comb begin
    for (int i = 0; i < bll_pkg::KW_COUNT; i++) begin
      match_mask[i] = bll_pkg::kw_hit(4'(i), lexeme_length, c);
      first_mask[i] = bll_pkg::kw_hit(4'(i), 16'd0, c);
    end
  end

  // keyword resolution, later entries win as in the spelling table
  always_comb begin
    word_kind = bll_pkg::TK_IDENT;
    for (int i = 0; i < bll_pkg::KW_COUNT; i++) begin
      if (keyword_mask[i] && lexeme_length == 16'(bll_pkg::KW_LEN[i])) begin
        word_kind = bll_pkg::KW_KIND[i];
      end
    end
  end

  // pending token
  always_comb begin
    ft = '0;
    ft.line_number  = line_out;
    ft.start_offset = token_start;
    ft.token_length = lexeme_length;
    flush_v = 1'b1;
    case (mode)
      M_ZERO: begin
        ft.token_kind = bll_pkg::TK_BOOL;
        ft.bit_count  = bll_pkg::COUNT_BITS'(1);
      end
      M_BITS: begin
        ft.token_kind   = (bits_seen == bll_pkg::COUNT_BITS'(1)) ?
                          bll_pkg::TK_BOOL : bll_pkg::TK_BITVEC;
        ft.bit_value    = 64'(bit_acc);
        ft.bit_count    = bits_seen;
        ft.bit_overflow = overflow_seen;
      end
      M_WORD: begin
        ft.token_kind = word_kind;
      end
      default: begin
        flush_v = 1'b0;
      end
    endcase
  end

  // token from a character seen afresh
  always_comb begin
    rt = '0;
    rt.line_number  = line_out;
    rt.start_offset = byte_offset;
    rt.token_length = 16'd1;
    rt_v = 1'b1;
    case (c) inside
      bll_pkg::CH_LPAREN: rt.token_kind = bll_pkg::TK_LPAREN;
      bll_pkg::CH_RPAREN: rt.token_kind = bll_pkg::TK_RPAREN;
      bll_pkg::CH_ONE: begin
        rt.token_kind = bll_pkg::TK_BOOL;
        rt.bit_value  = 64'd1;
        rt.bit_count  = bll_pkg::COUNT_BITS'(1);
      end
      bll_pkg::CH_SPACE, bll_pkg::CH_TAB, bll_pkg::CH_CR, bll_pkg::CH_LF,
      bll_pkg::CH_ZERO, bll_pkg::CH_UNDERSCORE,
      [bll_pkg::CH_LOWER_A:bll_pkg::CH_LOWER_Z],
      [bll_pkg::CH_UPPER_A:bll_pkg::CH_UPPER_Z]: rt_v = 1'b0;
      default: begin
        rt.token_kind = bll_pkg::TK_ERROR;
        rt.bad_char   = c;
      end
    endcase
  end

  always_comb begin
    eof_tok = '0;
    eof_tok.token_kind   = bll_pkg::TK_EOF;
    eof_tok.line_number  = line_out;
    eof_tok.start_offset = byte_offset;
  end

  assign consume = (mode == M_ZERO && c == bll_pkg::CH_B) ||
                   (mode == M_BITS && is_bit) ||
                   (mode == M_WORD && (is_letter || is_bit));

  assign first_v = (held_kind == bll_pkg::IN_END) ? flush_v : (!consume && flush_v);
  assign sec_v   = (held_kind == bll_pkg::IN_END) ? 1'b1 : (!consume && rt_v);
  assign sec     = (held_kind == bll_pkg::IN_END) ? eof_tok : rt;

  always_comb begin
    push.v0 = adv && (first_v || sec_v);
    push.v1 = adv && first_v && sec_v;
    push.t0 = first_v ? ft : sec;
    push.t0.last_of_run = !(first_v && sec_v);
    push.t1 = sec;
    push.t1.last_of_run = 1'b1;
  end

  always_comb begin
    mode_next          = mode;
    line_count_next    = line_count;
    byte_offset_next   = byte_offset + 32'd1;
    token_start_next   = token_start;
    lexeme_length_next = lexeme_length;
    bit_acc_next       = bit_acc;
    bits_seen_next     = bits_seen;
    overflow_seen_next = overflow_seen;
    keyword_mask_next  = keyword_mask;
    if (held_kind == bll_pkg::IN_END) begin
      mode_next          = M_IDLE;
      line_count_next    = LINE_BITS'(1);
      byte_offset_next   = '0;
      token_start_next   = '0;
      lexeme_length_next = '0;
      bit_acc_next       = '0;
      bits_seen_next     = '0;
      overflow_seen_next = 1'b0;
      keyword_mask_next  = '1;
    end else if (consume) begin
      lexeme_length_next = grown_length;
      if (mode == M_ZERO) begin
        mode_next = M_BITS;
      end else if (mode == M_BITS) begin
        if (bits_seen < bll_pkg::COUNT_BITS'(VALUE_BITS)) begin
          bit_acc_next   = {bit_acc[VALUE_BITS-2:0], c[0]};
          bits_seen_next = bits_seen + bll_pkg::COUNT_BITS'(1);
        end else begin
          overflow_seen_next = 1'b1;
        end
      end else begin
        keyword_mask_next = keyword_mask & match_mask;
      end
    end else begin
      mode_next = M_IDLE;
      if (c == bll_pkg::CH_LF && line_count != '1) begin
        line_count_next = line_count + LINE_BITS'(1);
      end
      if (c == bll_pkg::CH_ZERO || is_letter) begin
        mode_next          = (c == bll_pkg::CH_ZERO) ? M_ZERO : M_WORD;
        token_start_next   = byte_offset;
        lexeme_length_next = 16'd1;
        bit_acc_next       = '0;
        bits_seen_next     = '0;
        overflow_seen_next = 1'b0;
        keyword_mask_next  = (c == bll_pkg::CH_ZERO) ? '1 : first_mask;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_v        <= 1'b0;
      held_kind     <= bll_pkg::IN_CHAR;
      held_ch       <= '0;
      mode          <= M_IDLE;
      line_count    <= LINE_BITS'(1);
      byte_offset   <= '0;
      token_start   <= '0;
      lexeme_length <= '0;
      bit_acc       <= '0;
      bits_seen     <= '0;
      overflow_seen <= 1'b0;
      keyword_mask  <= '1;
    end else begin
      if (src.valid && src.ready) begin
        held_v    <= 1'b1;
        held_kind <= src.kind;
        held_ch   <= src.ch;
      end else if (adv) begin
        held_v <= 1'b0;
      end
      if (adv) begin
        mode          <= mode_next;
        line_count    <= line_count_next;
        byte_offset   <= byte_offset_next;
        token_start   <= token_start_next;
        lexeme_length <= lexeme_length_next;
        bit_acc       <= bit_acc_next;
        bits_seen     <= bits_seen_next;
        overflow_seen <= overflow_seen_next;
        keyword_mask  <= keyword_mask_next;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (adv && held_kind == bll_pkg::IN_END) |=>
      (mode == M_IDLE && byte_offset == '0 && line_count == LINE_BITS'(1)))
    else $error("end word did not return the scanner to its start state");

  a_pending_len: assert property (@(posedge clk) disable iff (rst)
    (mode != M_IDLE) |-> (lexeme_length != '0))
    else $error("pending token with zero length");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    push.v1 |-> (push.t1.last_of_run && !push.t0.last_of_run))
    else $error("last_of_run on the wrong word of a pair");
`endif

endmodule

@@ src/bll_queue.sv @@
module bll_queue (
  input  logic           clk,
  input  logic           rst,
  input  bll_pkg::push_t push,
  output logic           room,
  bll_tok_if.source      tok
);

  localparam int unsigned PTR_W = $clog2(bll_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  bll_pkg::token_t mem [bll_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic [1:0]       push_n;
  logic             pop;
  bll_pkg::token_t  head;

  assign push_n = {1'b0, push.v0} + {1'b0, push.v1};
  assign pop    = tok.valid && tok.ready;
  // room for a full pair regardless of what leaves this cycle
  assign room   = count <= CNT_W'(bll_pkg::QUEUE_DEPTH - 2);
  assign head   = mem[rd_ptr];

  assign tok.valid        = count != '0;
  assign tok.token_kind   = head.token_kind;
  assign tok.line_number  = head.line_number;
  assign tok.start_offset = head.start_offset;
  assign tok.token_length = head.token_length;
  assign tok.bit_value    = head.bit_value;
  assign tok.bit_count    = head.bit_count;
  assign tok.bit_overflow = head.bit_overflow;
  assign tok.bad_char     = head.bad_char;
  assign tok.last_of_run  = head.last_of_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push_n) - CNT_W'(pop);
    end
    if (push.v0) begin
      mem[wr_ptr] <= push.t0;
    end
    if (push.v1) begin
      mem[wr_ptr + PTR_W'(1)] <= push.t1;
    end
  end

`ifndef NO_ASSERTIONS
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push.v0 |-> room)
    else $error("word pushed into a full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(bll_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    push.v1 |-> push.v0)
    else $error("second word pushed without a first");
`endif

endmodule

@@ tb/lexer_checker.sv @@
module lexer_checker (
  input  logic clk,
  input  logic rst,
  bll_src_if   src,
  bll_tok_if   tok,
  output int   fail_count,
  output int   pending,
  output int   tokens_checked
);

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_ZERO, SCAN_BITS, SCAN_WORD} scan_t;

  scan_t                          mode;
  logic [15:0]                    line_cnt;
  logic [31:0]                    offset;
  logic [31:0]                    tok_start;
  logic [15:0]                    lex_len;
  logic [63:0]                    acc;
  logic [bll_pkg::COUNT_BITS-1:0] nbits;
  logic                           ovf;
  logic [bll_pkg::KW_COUNT-1:0]   kw_mask;

  bll_pkg::token_t tokens_due[$];
  bll_pkg::token_t step_tok[2];
  int              step_n;
  int              mismatches = 0;
  int              checked = 0;

  assign fail_count     = mismatches;
  assign tokens_checked = checked;

  function automatic logic is_letter(logic [7:0] c);
    return (c >= bll_pkg::CH_LOWER_A && c <= bll_pkg::CH_LOWER_Z) ||
           (c >= bll_pkg::CH_UPPER_A && c <= bll_pkg::CH_UPPER_Z) ||
           c == bll_pkg::CH_UNDERSCORE;
  endfunction

  // spellings are right aligned with the first character highest
  function automatic logic [7:0] kw_char(int idx, int pos);
    logic [8*bll_pkg::KW_MAX_LEN-1:0] text;
    text = bll_pkg::KW_TEXT[idx];
    return text[8*(int'(bll_pkg::KW_LEN[idx]) - 1 - pos) +: 8];
  endfunction

  task automatic clear_scan();
    mode      = SCAN_IDLE;
    line_cnt  = 16'd1;
    offset    = '0;
    tok_start = '0;
    lex_len   = '0;
    acc       = '0;
    nbits     = '0;
    ovf       = 1'b0;
    kw_mask   = '1;
  endtask

  task automatic add_token(bll_pkg::token_kind_t k, logic [31:0] start, logic [15:0] len,
                           logic [63:0] val, logic [bll_pkg::COUNT_BITS-1:0] cnt, logic o,
                           logic [7:0] bad);
    bll_pkg::token_t t;
    t              = '0;
    t.token_kind   = k;
    t.line_number  = line_cnt;
    t.start_offset = start;
    t.token_length = len;
    t.bit_value    = val;
    t.bit_count    = cnt;
    t.bit_overflow = o;
    t.bad_char     = bad;
    if (step_n < 2) begin
      step_tok[step_n] = t;
      step_n++;
    end
  endtask

  task automatic narrow_keywords(logic [7:0] c);
    for (int i = 0; i < bll_pkg::KW_COUNT; i++) begin
      if (lex_len >= 16'(bll_pkg::KW_LEN[i]) || kw_char(i, int'(lex_len)) != c)
        kw_mask[i] = 1'b0;
    end
  endtask

  task automatic lengthen();
    if (lex_len != 16'hffff) lex_len++;
  endtask

  task automatic open_token(scan_t m);
    mode      = m;
    tok_start = offset;
    lex_len   = 16'd1;
    acc       = '0;
    nbits     = '0;
    ovf       = 1'b0;
    kw_mask   = '1;
  endtask

  task automatic close_token();
    bll_pkg::token_kind_t k;
    k = bll_pkg::TK_IDENT;
    case (mode)
      SCAN_ZERO: add_token(bll_pkg::TK_BOOL, tok_start, lex_len, '0,
                           bll_pkg::COUNT_BITS'(1), 1'b0, '0);
      SCAN_BITS: add_token((nbits == bll_pkg::COUNT_BITS'(1)) ? bll_pkg::TK_BOOL :
                           bll_pkg::TK_BITVEC, tok_start, lex_len, acc, nbits, ovf, '0);
      SCAN_WORD: begin
        for (int i = 0; i < bll_pkg::KW_COUNT; i++) begin
          if (kw_mask[i] && lex_len == 16'(bll_pkg::KW_LEN[i])) k = bll_pkg::KW_KIND[i];
        end
        add_token(k, tok_start, lex_len, '0, '0, 1'b0, '0);
      end
      default: ;
    endcase
    mode = SCAN_IDLE;
  endtask

  task automatic take_fresh(logic [7:0] c);
    if (c == bll_pkg::CH_LPAREN) begin
      add_token(bll_pkg::TK_LPAREN, offset, 16'd1, '0, '0, 1'b0, '0);
    end else if (c == bll_pkg::CH_RPAREN) begin
      add_token(bll_pkg::TK_RPAREN, offset, 16'd1, '0, '0, 1'b0, '0);
    end else if (c == bll_pkg::CH_SPACE || c == bll_pkg::CH_TAB || c == bll_pkg::CH_CR) begin
    end else if (c == bll_pkg::CH_LF) begin
      if (line_cnt != 16'hffff) line_cnt++;
    end else if (c == bll_pkg::CH_ZERO) begin
      open_token(SCAN_ZERO);
    end else if (c == bll_pkg::CH_ONE) begin
      add_token(bll_pkg::TK_BOOL, offset, 16'd1, 64'd1, bll_pkg::COUNT_BITS'(1), 1'b0, '0);
    end else if (is_letter(c)) begin
      open_token(SCAN_WORD);
      lex_len = '0;
      narrow_keywords(c);
      lex_len = 16'd1;
    end else begin
      add_token(bll_pkg::TK_ERROR, offset, 16'd1, '0, '0, 1'b0, c);
    end
  endtask

  task automatic predict(logic k, logic [7:0] c);
    step_n = 0;
    if (k == bll_pkg::IN_END) begin
      close_token();
      add_token(bll_pkg::TK_EOF, offset, '0, '0, '0, 1'b0, '0);
      clear_scan();
    end else begin
      case (mode)
        SCAN_ZERO: begin
          if (c == bll_pkg::CH_B) begin
            mode = SCAN_BITS;
            lengthen();
          end else begin
            close_token();
            take_fresh(c);
          end
        end
        SCAN_BITS: begin
          if (c == bll_pkg::CH_ZERO || c == bll_pkg::CH_ONE) begin
            // bits past the top are dropped, only the flag records them
            if (nbits < bll_pkg::COUNT_BITS'(64)) begin
              acc = {acc[62:0], c == bll_pkg::CH_ONE};
              nbits++;
            end else begin
              ovf = 1'b1;
            end
            lengthen();
          end else begin
            close_token();
            take_fresh(c);
          end
        end
        SCAN_WORD: begin
          if (is_letter(c) || c == bll_pkg::CH_ZERO || c == bll_pkg::CH_ONE) begin
            narrow_keywords(c);
            lengthen();
          end else begin
            close_token();
            take_fresh(c);
          end
        end
        default: take_fresh(c);
      endcase
      offset++;
    end
    if (step_n > 0) step_tok[step_n-1].last_of_run = 1'b1;
    for (int i = 0; i < step_n; i++) tokens_due.insert(tokens_due.size(), step_tok[i]);
  endtask

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      report($sformatf("token %0d %s got %0h want %0h", checked, name, got, want));
  endtask

  always @(posedge clk) begin
    bll_pkg::token_t want;
    if (rst) begin
      clear_scan();
      tokens_due.delete();
    end else begin
      if (src.valid && src.ready) predict(src.kind, src.ch);
      if (tok.valid && tok.ready) begin
        if (tokens_due.size() == 0) begin
          report($sformatf("token kind %0d at offset %0d with nothing expected",
                           tok.token_kind, tok.start_offset));
        end else begin
          want = tokens_due.pop_front();
          check_field("token_kind", tok.token_kind, want.token_kind);
          check_field("line_number", tok.line_number, want.line_number);
          check_field("start_offset", tok.start_offset, want.start_offset);
          check_field("token_length", tok.token_length, want.token_length);
          check_field("bit_value", tok.bit_value, want.bit_value);
          check_field("bit_count", tok.bit_count, want.bit_count);
          check_field("bit_overflow", tok.bit_overflow, want.bit_overflow);
          check_field("bad_char", tok.bad_char, want.bad_char);
          check_field("last_of_run", tok.last_of_run, want.last_of_run);
        end
        checked++;
      end
    end
    pending <= tokens_due.size();
  end

endmodule

@@ tb/tb_top.sv @@
module tb_top;

  typedef enum {RX_STEADY, RX_LIGHT, RX_PERIODIC, RX_HEAVY} rx_mode_t;

  logic clk;
  logic rst;
  int   fails;
  int   tokens_left;
  int   tokens_seen;
  int   words_sent = 0;
  int   burst_left;

  bll_src_if src_ch();
  bll_tok_if tok_ch();

  boolean_language_lexer dut (
    .clk (clk),
    .rst (rst),
    .src (src_ch),
    .tok (tok_ch)
  );

  lexer_checker chk (
    .clk            (clk),
    .rst            (rst),
    .src            (src_ch),
    .tok            (tok_ch),
    .fail_count     (fails),
    .pending        (tokens_left),
    .tokens_checked (tokens_seen)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #50000000;
    $display("TEST FAILED");
    $finish;
  end

  // receiver: phases of steady, light, periodic and heavy back-pressure
  initial begin
    rx_mode_t rx_mode;
    int       phase_left;
    tok_ch.ready = 1'b0;
    rx_mode      = RX_STEADY;
    phase_left   = 0;
    forever begin
      @(posedge clk);
      if (phase_left == 0) begin
        rx_mode    = rx_mode_t'($urandom_range(0, 3));
        phase_left = $urandom_range(20, 300);
      end
      phase_left--;
      case (rx_mode)
        RX_STEADY:   tok_ch.ready <= 1'b1;
        RX_LIGHT:    tok_ch.ready <= ($urandom_range(0, 9) >= 3);
        RX_PERIODIC: tok_ch.ready <= (phase_left % 4 != 0);
        default:     tok_ch.ready <= ($urandom_range(0, 9) >= 7);
      endcase
    end
  end

  task automatic send(logic k, logic [7:0] c);
    int gap;
    src_ch.valid <= 1'b1;
    src_ch.kind  <= k;
    src_ch.ch    <= c;
    do @(posedge clk); while (!src_ch.ready);
    words_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 20);
      if (gap > 0) begin
        src_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send(bll_pkg::IN_CHAR, s[i]);
  endtask

  // letters and underscore up to index 52, then the two digits
  function automatic logic [7:0] word_char(int top);
    string set;
    set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_01";
    return set[$urandom_range(0, top)];
  endfunction

  function automatic logic [7:0] spacer();
    case ($urandom_range(0, 7))
      0, 1, 2: return bll_pkg::CH_SPACE;
      3:       return bll_pkg::CH_TAB;
      4:       return bll_pkg::CH_CR;
      5:       return bll_pkg::CH_LF;
      6:       return bll_pkg::CH_LPAREN;
      default: return bll_pkg::CH_RPAREN;
    endcase
  endfunction

  task automatic send_lexeme();
    int                               pick;
    int                               n;
    int                               idx;
    logic [8*bll_pkg::KW_MAX_LEN-1:0] text;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      // keyword, now and then cut short or run on into an identifier
      idx  = $urandom_range(0, bll_pkg::KW_COUNT - 1);
      text = bll_pkg::KW_TEXT[idx];
      n    = int'(bll_pkg::KW_LEN[idx]);
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
      for (int p = 0; p < n; p++)
        send(bll_pkg::IN_CHAR, text[8*(int'(bll_pkg::KW_LEN[idx]) - 1 - p) +: 8]);
      if ($urandom_range(0, 5) == 0) send(bll_pkg::IN_CHAR, word_char(54));
    end else if (pick < 40) begin
      send(bll_pkg::IN_CHAR, word_char(52));
      repeat ($urandom_range(0, 10)) send(bll_pkg::IN_CHAR, word_char(54));
    end else if (pick < 58) begin
      send(bll_pkg::IN_CHAR, bll_pkg::CH_ZERO);
      send(bll_pkg::IN_CHAR, bll_pkg::CH_B);
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
      repeat (n)
        send(bll_pkg::IN_CHAR, $urandom_range(0, 1) ? bll_pkg::CH_ONE : bll_pkg::CH_ZERO);
    end else if (pick < 66) begin
      send(bll_pkg::IN_CHAR, $urandom_range(0, 1) ? bll_pkg::CH_ONE : bll_pkg::CH_ZERO);
    end else if (pick < 76) begin
      send(bll_pkg::IN_CHAR, $urandom_range(0, 1) ? bll_pkg::CH_LPAREN : bll_pkg::CH_RPAREN);
    end else if (pick < 84) begin
      send(bll_pkg::IN_CHAR, spacer());
    end else if (pick < 97) begin
      send(bll_pkg::IN_CHAR, 8'($urandom_range(0, 255)));
    end else begin
      send(bll_pkg::IN_END, 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 9) < 6) send(bll_pkg::IN_CHAR, spacer());
  endtask

  initial begin
    rst          = 1'b1;
    src_ch.valid = 1'b0;
    src_ch.kind  = bll_pkg::IN_CHAR;
    src_ch.ch    = 8'h00;
    burst_left   = $urandom_range(1, 20);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_text("(1)0 0b 0b1 0b01");
    send(bll_pkg::IN_CHAR, 8'h00);
    send(bll_pkg::IN_CHAR, 8'h80);
    send(bll_pkg::IN_CHAR, 8'hff);
    send(bll_pkg::IN_CHAR, bll_pkg::CH_LF);
    send(bll_pkg::IN_CHAR, bll_pkg::CH_TAB);
    send(bll_pkg::IN_CHAR, bll_pkg::CH_CR);
    send_text("0a");
    send(bll_pkg::IN_END, 8'hff);

    while (words_sent < 1950) send_lexeme();
    send(bll_pkg::IN_END, 8'h00);
    if (src_ch.valid) src_ch.valid <= 1'b0;

    // the pending count is a registered copy of the checker's queue size
    @(posedge clk);
    while (tokens_left != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d words: keywords, identifiers, literals up to 70 bits, bad bytes",
             words_sent);
    $display("and end words under bursty input and output stalls; %0d tokens compared",
             tokens_seen);
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
